// ----- rtl/tml_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tml_pkg
// Widths, limits and the result type shared by the tile majority label core.
// ----------------------------------------------------------------------------
package tml_pkg;

    localparam int LBL_W         = 10;
    localparam int CNT_W         = 11;
    localparam int NUM_LABELS    = 1024;
    localparam int MAX_TILE_SIDE = 32;
    localparam int ADDR_W        = $clog2(NUM_LABELS);

    // Tile tag kept next to each histogram count.
    localparam int EPOCH_W       = 8;
    localparam int MEM_W         = EPOCH_W + CNT_W;

    localparam int CNT_MAX       = (1 << CNT_W) - 1;
    localparam int CAP_RAW       = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int CAP_INT       = (CAP_RAW > CNT_MAX) ? CNT_MAX : CAP_RAW;
    localparam logic [CNT_W-1:0]   COUNT_CAP = CNT_W'(CAP_INT);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
    localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(NUM_LABELS - 1);

    typedef struct packed {
        logic [LBL_W-1:0] label;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/tile_majority_label_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tile_majority_label_core
// Majority label of an image tile, counted in a tagged histogram memory.
// ----------------------------------------------------------------------------
// Usage:
// Pixel labels enter on the i_valid/o_stall channel, one request per pixel,
// with i_tile_end high on the tile's last pixel. Label 0 is background.
// One result request per tile leaves on the o_valid/i_stall channel: the
// most frequent nonzero label (smallest on a tie), its count, and an empty
// flag for a tile without labelled pixels.
// Throughput is one pixel per cycle while o_stall is low, set by the single
// read-modify-write of the histogram memory per pixel; back-to-back hits on
// one label are forwarded. A result is pushed from stage 1 into a two-entry
// output queue, so the input keeps flowing while the receiver stalls; the
// queue stalls input once it is full, counting a result still in stage 1.
// Each histogram entry carries an 8-bit tile tag, so a new tile needs no
// clearing. After reset, and after every 256th tile when the tag wraps, a
// clearing pass writes all 1024 entries, one per cycle; input is stalled
// during the pass and while the wrapping tile's last pixel drains.
// ----------------------------------------------------------------------------
module tile_majority_label_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire [tml_pkg::LBL_W-1:0] i_pixel_label,
    input  wire                      i_tile_end,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic [tml_pkg::LBL_W-1:0] o_winner_label,
    output logic [tml_pkg::CNT_W-1:0] o_winner_count,
    output logic                     o_tile_empty
);
    import tml_pkg::*;

    logic [MEM_W-1:0]   r_mem [NUM_LABELS];
    logic [MEM_W-1:0]   r_rd_data;

    logic               r_sweep;
    logic [ADDR_W-1:0]  r_sweep_addr;
    logic [EPOCH_W-1:0] r_epoch;

    logic               r_s1_vld;
    logic [LBL_W-1:0]   r_s1_lab;
    logic               r_s1_last;

    logic               r_fw_vld;
    logic [LBL_W-1:0]   r_fw_lab;
    logic [CNT_W-1:0]   r_fw_cnt;

    logic [CNT_W-1:0]   r_best_cnt, n_best_cnt;
    logic [LBL_W-1:0]   r_best_lab, n_best_lab;

    t_result            r_q [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_q_cnt;

    logic               w_accept, w_pop, w_push, w_counted, w_we;
    logic [ADDR_W-1:0]  w_wa;
    logic [MEM_W-1:0]   w_wd;
    logic [CNT_W-1:0]   w_base, w_inc;
    logic [1:0]         w_pend;
    t_result            w_res;

    // Input stall: clearing pass, a wrapping tile draining, or a full queue.
    always_comb begin
        w_pend  = {1'b0, r_s1_vld && r_s1_last};
        o_stall = r_sweep || ((r_q_cnt + w_pend) >= 2'd2) ||
                  (r_s1_vld && r_s1_last && (r_epoch == EPOCH_LAST));
    end

    assign w_accept = i_valid && !o_stall;
    assign w_pop    = o_valid && !i_stall;

    // Stage 1: resolve the count, increment with saturation, update the best.
    always_comb begin
        w_counted = (32'(r_s1_lab) != 0) && (32'(r_s1_lab) < NUM_LABELS);
        if (r_fw_vld && (r_fw_lab == r_s1_lab)) begin
            w_base = r_fw_cnt;
        end else if (r_rd_data[CNT_W +: EPOCH_W] == r_epoch) begin
            w_base = r_rd_data[CNT_W-1:0];
        end else begin
            w_base = '0;
        end
        w_inc = (w_base < COUNT_CAP) ? w_base + CNT_W'(1) : w_base;
        w_we  = r_s1_vld && w_counted;

        n_best_cnt = r_best_cnt;
        n_best_lab = r_best_lab;
        if (w_we && ((w_inc > r_best_cnt) ||
                     ((w_inc == r_best_cnt) && (r_s1_lab < r_best_lab)))) begin
            n_best_cnt = w_inc;
            n_best_lab = r_s1_lab;
        end

        w_push = r_s1_vld && r_s1_last;
        if (n_best_cnt == '0) begin
            w_res = '{label: '0, count: '0, empty: 1'b1};
        end else begin
            w_res = '{label: n_best_lab, count: n_best_cnt, empty: 1'b0};
        end

        if (r_sweep) begin
            w_wa = r_sweep_addr;
            w_wd = {r_epoch, {CNT_W{1'b0}}};
        end else begin
            w_wa = ADDR_W'(r_s1_lab);
            w_wd = {r_epoch, w_inc};
        end
    end

    // Histogram memory: one read and one write port, read data registered.
    always_ff @(posedge i_clk) begin
        if (r_sweep || w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_accept) begin
            r_rd_data <= r_mem[ADDR_W'(i_pixel_label)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_epoch      <= '0;
            r_s1_vld     <= 1'b0;
            r_fw_vld     <= 1'b0;
            r_best_cnt   <= '0;
            r_best_lab   <= '0;
            r_wp         <= 1'b0;
            r_rp         <= 1'b0;
            r_q_cnt      <= '0;
        end else begin
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + ADDR_W'(1);
                if (r_sweep_addr == ADDR_LAST) begin
                    r_sweep <= 1'b0;
                end
            end

            r_s1_vld <= w_accept;
            // Forward only within one tile; the tag change hides older counts.
            r_fw_vld <= w_we && !r_s1_last;

            if (w_push) begin
                r_best_cnt <= '0;
                r_best_lab <= '0;
                r_epoch    <= r_epoch + EPOCH_W'(1);
                if (r_epoch == EPOCH_LAST) begin
                    r_sweep      <= 1'b1;
                    r_sweep_addr <= '0;
                end
                r_wp <= ~r_wp;
            end else begin
                r_best_cnt <= n_best_cnt;
                r_best_lab <= n_best_lab;
            end

            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_q_cnt <= r_q_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_lab  <= i_pixel_label;
            r_s1_last <= i_tile_end;
        end
        r_fw_lab <= r_s1_lab;
        r_fw_cnt <= w_inc;
        if (w_push) begin
            r_q[r_wp] <= w_res;
        end
    end

    always_comb begin
        o_valid        = (r_q_cnt != 2'd0);
        o_winner_label = r_q[r_rp].label;
        o_winner_count = r_q[r_rp].count;
        o_tile_empty   = r_q[r_rp].empty;
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 2'd2)
        else $error("output queue holds more than two results");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> ((r_q_cnt != 2'd2) || w_pop))
        else $error("result pushed into a full output queue");

    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> (!r_s1_vld && !w_accept))
        else $error("pixel in flight during clearing pass");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tile_empty) |-> ((o_winner_count == '0) && (o_winner_label == '0)))
        else $error("empty tile result carries a winner");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tile_empty) |-> ((o_winner_count != '0) &&
                                        (o_winner_count <= COUNT_CAP)))
        else $error("winner count out of range");

endmodule
`default_nettype wire
